// ===== hw/rtl/afc_pkg.sv =====
// Shared types and constants for the AABB frustum cull test block.
// Used by afc_ctrl, afc_datapath and aabb_frustum_cull_test; no dependencies.
package afc_pkg;

   localparam int NORMAL_W     = 16;  // signed Q1.14 normal component
   localparam int COORD_W      = 32;  // signed Q23.8 centre and offset
   localparam int EXTENT_W     = 24;  // unsigned Q16.8 half extent
   localparam int INDEX_W      = 3;   // plane_index field
   localparam int NSUM_W       = 17;  // sum of three normal magnitudes
   localparam int PROD_W       = NORMAL_W + COORD_W;
   localparam int RADIUS_W     = EXTENT_W + NSUM_W;
   localparam int ACC_W        = 53;  // holds r + dist exactly with a sign bit
   localparam int OFFSET_SHIFT = 14;  // aligns Q.8 offset with Q.22 products

   localparam int DRAIN_CYCLES = 2;   // stages after the product registers
   localparam int DRAIN_W      = 1;

   localparam logic [EXTENT_W-1:0] HALF_EXTENT_RESET = 24'd2048;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_TEST = 1'b1;

   typedef struct packed {
      logic load;      // write one plane from the request beat
      logic start;     // latch the centre and arm the pass flag
      logic issue;     // send the selected plane into the pipeline
      logic publish;   // move the pass flag into the response register
   } afc_cmd_type;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_RUN    = 4'b0010,
      ST_DRAIN  = 4'b0100,
      ST_FINISH = 4'b1000
   } afc_state_type;

endpackage

// ===== hw/rtl/afc_ctrl.sv =====
// Controller for the cull test: request decode, plane sequencing and
// response handshake. Depends on afc_pkg.
module afc_ctrl #(
   parameter int PLANE_COUNT = 6,
   parameter int IDX_W       = 3
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_opcode,
   output logic                      req_ready,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output afc_pkg::afc_cmd_type      cmd,
   output logic [IDX_W-1:0]          plane_sel
);
   import afc_pkg::*;

   localparam logic [IDX_W-1:0]   LAST_PLANE = IDX_W'(PLANE_COUNT - 1);
   localparam logic [DRAIN_W-1:0] LAST_DRAIN = DRAIN_W'(DRAIN_CYCLES - 1);

   afc_state_type      state_ff, state_in;
   logic [IDX_W-1:0]   cnt_ff, cnt_in;
   logic [DRAIN_W-1:0] drain_ff, drain_in;
   logic               rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      drain_in  = drain_ff;
      req_ready = 1'b0;
      cmd       = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_opcode == OP_TEST) begin
                  cmd.start = 1'b1;
                  cnt_in    = '0;
                  state_in  = ST_RUN;
               end else begin
                  cmd.load = 1'b1;
               end
            end
         end
         ST_RUN: begin
            cmd.issue = 1'b1;
            if (cnt_ff == LAST_PLANE) begin
               drain_in = '0;
               state_in = ST_DRAIN;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            if (drain_ff == LAST_DRAIN) begin
               state_in = ST_FINISH;
            end else begin
               drain_in = drain_ff + 1'b1;
            end
         end
         ST_FINISH: begin
            // Wait here only if the previous result has not been taken yet.
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.publish = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.publish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         drain_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         drain_ff     <= drain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign plane_sel = cnt_ff;
   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== hw/rtl/afc_datapath.sv =====
// Datapath for the cull test: plane store, half extent register, product
// stage, sum stage and the pass flag. Depends on afc_pkg.
module afc_datapath #(
   parameter int PLANE_COUNT = 6,
   parameter int IDX_W       = 3
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  afc_pkg::afc_cmd_type                   cmd,
   input  logic [IDX_W-1:0]                       plane_sel,
   input  logic [afc_pkg::INDEX_W-1:0]            req_plane_index,
   input  logic signed [afc_pkg::NORMAL_W-1:0]    req_normal_x,
   input  logic signed [afc_pkg::NORMAL_W-1:0]    req_normal_y,
   input  logic signed [afc_pkg::NORMAL_W-1:0]    req_normal_z,
   input  logic signed [afc_pkg::COORD_W-1:0]     req_plane_offset,
   input  logic signed [afc_pkg::COORD_W-1:0]     req_center_x,
   input  logic signed [afc_pkg::COORD_W-1:0]     req_center_y,
   input  logic signed [afc_pkg::COORD_W-1:0]     req_center_z,
   input  logic                                   csr_wr_en,
   input  logic [afc_pkg::EXTENT_W-1:0]           csr_wr_data,
   output logic                                   rsp_in_view
);
   import afc_pkg::*;

   // Plane store; the magnitude sum is computed once at load time.
   logic signed [NORMAL_W-1:0] nx_ff [PLANE_COUNT];
   logic signed [NORMAL_W-1:0] ny_ff [PLANE_COUNT];
   logic signed [NORMAL_W-1:0] nz_ff [PLANE_COUNT];
   logic signed [COORD_W-1:0]  off_ff [PLANE_COUNT];
   logic [NSUM_W-1:0]          nsum_ff [PLANE_COUNT];

   logic [EXTENT_W-1:0]        half_extent_ff;
   logic signed [COORD_W-1:0]  cx_ff, cy_ff, cz_ff;

   logic [IDX_W-1:0]           wr_idx;
   logic                       wr_en;
   logic [NSUM_W-1:0]          ax, ay, az, nsum_in;

   // Product stage.
   logic signed [PROD_W-1:0]   px_ff, py_ff, pz_ff, px_in, py_in, pz_in;
   logic [RADIUS_W-1:0]        r_ff, r_in;
   logic signed [COORD_W-1:0]  poff_ff;
   logic                       a_vld_ff;

   // Sum stage.
   logic [ACC_W-1:0]           s1_ff, s2_ff, s1_in, s2_in, total;
   logic                       b_vld_ff;
   logic                       ok_ff, ok_in;
   logic                       in_view_ff;

   function automatic logic [NSUM_W-1:0] mag(input logic signed [NORMAL_W-1:0] v);
      logic [NSUM_W-1:0] w;
      w = {v[NORMAL_W-1], v};
      return v[NORMAL_W-1] ? (~w + 1'b1) : w;
   endfunction

   function automatic logic [ACC_W-1:0] sext_prod(input logic [PROD_W-1:0] v);
      return {{(ACC_W - PROD_W){v[PROD_W-1]}}, v};
   endfunction

   assign wr_idx     = IDX_W'(req_plane_index);
   assign wr_en      = cmd.load && (int'(req_plane_index) < PLANE_COUNT);
   assign ax         = mag(req_normal_x);
   assign ay         = mag(req_normal_y);
   assign az         = mag(req_normal_z);
   assign nsum_in    = ax + ay + az;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PLANE_COUNT; i++) begin
            nx_ff[i]   <= '0;
            ny_ff[i]   <= '0;
            nz_ff[i]   <= '0;
            off_ff[i]  <= '0;
            nsum_ff[i] <= '0;
         end
      end else if (wr_en) begin
         nx_ff[wr_idx]   <= req_normal_x;
         ny_ff[wr_idx]   <= req_normal_y;
         nz_ff[wr_idx]   <= req_normal_z;
         off_ff[wr_idx]  <= req_plane_offset;
         nsum_ff[wr_idx] <= nsum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         half_extent_ff <= HALF_EXTENT_RESET;
      end else if (csr_wr_en) begin
         half_extent_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         cx_ff <= req_center_x;
         cy_ff <= req_center_y;
         cz_ff <= req_center_z;
      end
   end

   assign px_in = nx_ff[plane_sel] * cx_ff;
   assign py_in = ny_ff[plane_sel] * cy_ff;
   assign pz_in = nz_ff[plane_sel] * cz_ff;
   assign r_in  = half_extent_ff * nsum_ff[plane_sel];

   always_ff @(posedge clock) begin
      px_ff   <= px_in;
      py_ff   <= py_in;
      pz_ff   <= pz_in;
      r_ff    <= r_in;
      poff_ff <= off_ff[plane_sel];
   end

   // The sum r + dist is split in two halves that the sum stage registers and
   // then adds for the sign test; the Q.8 offset is moved up to the Q.22 scale of the products.
   assign s1_in = sext_prod(px_ff) + sext_prod(py_ff);
   assign s2_in = sext_prod(pz_ff)
                + {{(ACC_W - RADIUS_W){1'b0}}, r_ff}
                - {{(ACC_W - COORD_W - OFFSET_SHIFT){poff_ff[COORD_W-1]}},
                   poff_ff, {OFFSET_SHIFT{1'b0}}};

   always_ff @(posedge clock) begin
      s1_ff <= s1_in;
      s2_ff <= s2_in;
   end

   assign total = s1_ff + s2_ff;

   always_comb begin
      ok_in = ok_ff;
      if (cmd.start) begin
         ok_in = 1'b1;
      end else if (b_vld_ff && total[ACC_W-1]) begin
         ok_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
         b_vld_ff <= 1'b0;
         ok_ff    <= 1'b1;
      end else begin
         a_vld_ff <= cmd.issue;
         b_vld_ff <= a_vld_ff;
         ok_ff    <= ok_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.publish) begin
         in_view_ff <= ok_ff;
      end
   end

   assign rsp_in_view = in_view_ff;

endmodule

// ===== hw/rtl/aabb_frustum_cull_test.sv =====
// AABB frustum cull test, top level. A load beat gives no response. A test
// beat walks the planes one per cycle through a product stage and a sum stage;
// no new beat is taken until its response is shown, which the finish state
// holds back while an earlier response has not been taken.
// Synchronous reset clears all planes to zero and sets the half extent to 8.0.
// Depends on afc_pkg, afc_ctrl and afc_datapath.
module aabb_frustum_cull_test #(
   parameter int PLANE_COUNT = 6
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic                                   req_opcode,
   input  logic [afc_pkg::INDEX_W-1:0]            req_plane_index,
   input  logic signed [afc_pkg::NORMAL_W-1:0]    req_normal_x,
   input  logic signed [afc_pkg::NORMAL_W-1:0]    req_normal_y,
   input  logic signed [afc_pkg::NORMAL_W-1:0]    req_normal_z,
   input  logic signed [afc_pkg::COORD_W-1:0]     req_plane_offset,
   input  logic signed [afc_pkg::COORD_W-1:0]     req_center_x,
   input  logic signed [afc_pkg::COORD_W-1:0]     req_center_y,
   input  logic signed [afc_pkg::COORD_W-1:0]     req_center_z,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic                                   rsp_in_view,
   input  logic                                   csr_wr_en,
   input  logic [afc_pkg::EXTENT_W-1:0]           csr_wr_data
);
   import afc_pkg::*;

   localparam int IDX_W = (PLANE_COUNT > 1) ? $clog2(PLANE_COUNT) : 1;

   afc_cmd_type      cmd;
   logic [IDX_W-1:0] plane_sel;

   afc_ctrl #(
      .PLANE_COUNT(PLANE_COUNT),
      .IDX_W      (IDX_W)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_opcode(req_opcode),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .plane_sel (plane_sel)
   );

   afc_datapath #(
      .PLANE_COUNT(PLANE_COUNT),
      .IDX_W      (IDX_W)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .plane_sel       (plane_sel),
      .req_plane_index (req_plane_index),
      .req_normal_x    (req_normal_x),
      .req_normal_y    (req_normal_y),
      .req_normal_z    (req_normal_z),
      .req_plane_offset(req_plane_offset),
      .req_center_x    (req_center_x),
      .req_center_y    (req_center_y),
      .req_center_z    (req_center_z),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .rsp_in_view     (rsp_in_view)
   );

endmodule
